// File: rtl/art_pkg.sv
// Package for the address range table: sizes, command codes, state codes.
// Used by art_store and address_range_table; depends on nothing.
`default_nettype none
package art_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_BITS   = 48;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_FORGET = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_RESOLVE,
        ST_WRITE,
        ST_DONE
    } state_t;

    // range table entry
    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [47:0]          length;
        logic [31:0]          flags;
        logic [31:0]          device;
        logic [63:0]          handle;
        logic [63:0]          offset;
    } range_entry_t;

    // link table entry
    typedef struct packed {
        logic [63:0]          handle;
        logic [ADDR_BITS-1:0] base;
    } link_entry_t;

    // memory port bundle from sequencer to the store
    typedef struct packed {
        logic [IDX_BITS-1:0] raddr;
        logic                rwe;
        logic [IDX_BITS-1:0] rwaddr;
        range_entry_t        rwdata;
        logic [IDX_BITS-1:0] laddr;
        logic                lwe;
        logic [IDX_BITS-1:0] lwaddr;
        link_entry_t         lwdata;
    } mem_req_t;
endpackage
`default_nettype wire

// File: rtl/art_store.sv
// Range and link tables: two synchronous memories with registered read.
// Depends on art_pkg.
`default_nettype none
module art_store (
    input  wire logic              clk,
    input  wire art_pkg::mem_req_t req,
    output art_pkg::range_entry_t  rdata,
    output art_pkg::link_entry_t   ldata
);
    import art_pkg::*;

    range_entry_t range_mem [TABLE_DEPTH];
    link_entry_t  link_mem  [TABLE_DEPTH];

    // range table port
    always_ff @(posedge clk)
    begin
        if (req.rwe)
            range_mem[req.rwaddr] <= req.rwdata;
        rdata <= range_mem[req.raddr];
    end

    // link table port
    always_ff @(posedge clk)
    begin
        if (req.lwe)
            link_mem[req.lwaddr] <= req.lwdata;
        ldata <= link_mem[req.laddr];
    end
endmodule
`default_nettype wire

// File: rtl/address_range_table.sv
// Address range table top level: command sequencer with valid bits, over art_store.
// Depends on art_pkg and art_store.
//
// channel | handshake          | fields
// command | start / busy       | command address length alloc_flags device_id
//         |                    | owner_handle map_offset
// result  | done (one cycle)   | hit forgot table_full found_* recorded_count
//
// Record, forget and find scan both tables once, one entry a cycle through the
// memory read port, then fetch, resolve, write back and present the result.
// A forget whose handle is linked scans a second time for the linked base.
// Clear skips the scan: valid bits are flip-flops cleared at once.
// Reset clears valid bits, total and state; memories are not cleared.
// busy is high from acceptance until the result strobe; results cannot stall.
`default_nettype none
module address_range_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    command,
    input  wire logic [art_pkg::ADDR_BITS-1:0] address,
    input  wire logic [47:0]                   length,
    input  wire logic [31:0]                   alloc_flags,
    input  wire logic [31:0]                   device_id,
    input  wire logic [63:0]                   owner_handle,
    input  wire logic [63:0]                   map_offset,
    output logic                               done,
    output logic                               hit,
    output logic                               forgot,
    output logic                               table_full,
    output logic [art_pkg::ADDR_BITS-1:0]      found_base,
    output logic [47:0]                        found_length,
    output logic [31:0]                        found_flags,
    output logic [31:0]                        found_device,
    output logic [63:0]                        found_handle,
    output logic [63:0]                        found_offset,
    output logic [31:0]                        recorded_count
);
    import art_pkg::*;

    state_t               state_reg, state_next;
    logic [TABLE_DEPTH-1:0] rvalid_reg, lvalid_reg;
    logic [31:0]          total_reg;
    cmd_t                 cmd_reg;
    range_entry_t         in_reg;
    // scan counter: issues reads 0..DEPTH-1, data follows in the next cycle
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 dv_reg;
    logic [IDX_BITS-1:0]  didx_reg;
    // scan findings
    logic                 rm_reg, lm_reg, rf_reg, lf_reg, bst_reg;
    logic [IDX_BITS-1:0]  rmi_reg, lmi_reg, rfi_reg, lfi_reg, bi_reg;
    logic [ADDR_BITS-1:0] bb_reg;
    logic                 fwd_reg;
    logic                 pass_reg;
    link_entry_t          lent_reg;

    mem_req_t             req;
    range_entry_t         rdata;
    link_entry_t          ldata;

    art_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata),
        .ldata (ldata)
    );

    // result register fields
    logic                 hit_reg, forgot_reg, full_reg, done_reg;
    range_entry_t         found_reg;

    // state register, valid bits, total and scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= '0;
            lvalid_reg <= '0;
            total_reg  <= '0;
            done_reg   <= 1'b0;
            dv_reg     <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= 1'b0;
            dv_reg    <= (state_reg == ST_SCAN) && (cnt_reg < CNT_BITS'(TABLE_DEPTH));
            case (state_reg)
                ST_WRITE:
                begin
                    done_reg <= 1'b1;
                    case (cmd_reg)
                        CMD_RECORD:
                        begin
                            if (in_reg.base != '0 && (rm_reg || rf_reg)
                                && (lm_reg || lf_reg))
                            begin
                                rvalid_reg[rm_reg ? rmi_reg : rfi_reg] <= 1'b1;
                                lvalid_reg[lm_reg ? lmi_reg : lfi_reg] <= 1'b1;
                                total_reg <= total_reg + 32'd1;
                            end
                        end
                        CMD_FORGET:
                        begin
                            if (lm_reg)
                            begin
                                lvalid_reg[lmi_reg] <= 1'b0;
                                if (fwd_reg)
                                    rvalid_reg[rmi_reg] <= 1'b0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            rvalid_reg <= '0;
                            lvalid_reg <= '0;
                            total_reg  <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload, scan findings and result flags
    always_ff @(posedge clk)
    begin
        didx_reg <= cnt_reg[IDX_BITS-1:0];
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg       <= cmd_t'(command);
            in_reg.base   <= address;
            in_reg.length <= length;
            in_reg.flags  <= alloc_flags;
            in_reg.device <= device_id;
            in_reg.handle <= owner_handle;
            in_reg.offset <= map_offset;
            rm_reg <= 1'b0; lm_reg <= 1'b0; rf_reg <= 1'b0;
            lf_reg <= 1'b0; bst_reg <= 1'b0; pass_reg <= 1'b0;
            hit_reg <= 1'b0; forgot_reg <= 1'b0; full_reg <= 1'b0;
            found_reg <= '0;
        end
        // first-match, first-free and best-base search over each scanned entry
        if (dv_reg)
        begin
            if (rvalid_reg[didx_reg])
            begin
                if (!rm_reg && rdata.base == in_reg.base)
                begin
                    rm_reg <= 1'b1; rmi_reg <= didx_reg;
                end
                if (rdata.base <= in_reg.base && (!bst_reg || rdata.base > bb_reg))
                begin
                    bst_reg <= 1'b1; bi_reg <= didx_reg; bb_reg <= rdata.base;
                end
            end
            else if (!rf_reg)
            begin
                rf_reg <= 1'b1; rfi_reg <= didx_reg;
            end
            if (lvalid_reg[didx_reg])
            begin
                if (!lm_reg && ldata.handle == in_reg.handle)
                begin
                    lm_reg <= 1'b1; lmi_reg <= didx_reg; lent_reg <= ldata;
                end
            end
            else if (!lf_reg)
            begin
                lf_reg <= 1'b1; lfi_reg <= didx_reg;
            end
        end
        // forget: second pass searches the range table for the linked base
        if (state_reg == ST_SCAN && cnt_reg == CNT_BITS'(TABLE_DEPTH) && !dv_reg
            && cmd_reg == CMD_FORGET && lm_reg && !pass_reg)
        begin
            pass_reg    <= 1'b1;
            in_reg.base <= lent_reg.base;
            rm_reg      <= 1'b0;
        end
        // find: containment test; record: full flag
        if (state_reg == ST_RESOLVE)
        begin
            if (cmd_reg == CMD_FIND && bst_reg
                && (in_reg.base - rdata.base) < ADDR_BITS'(rdata.length))
            begin
                hit_reg   <= 1'b1;
                found_reg <= rdata;
            end
            if (cmd_reg == CMD_RECORD && in_reg.base != '0
                && !((rm_reg || rf_reg) && (lm_reg || lf_reg)))
                full_reg <= 1'b1;
        end
        if (state_reg == ST_WRITE)
            fwd_reg <= 1'b0;
        if (state_reg == ST_FETCH)
            fwd_reg <= 1'b0;
        if (state_reg == ST_RESOLVE && cmd_reg == CMD_FORGET)
        begin
            fwd_reg    <= rm_reg && rdata.handle == in_reg.handle;
            forgot_reg <= lm_reg && rm_reg && rdata.handle == in_reg.handle;
        end
    end

    // next state and memory requests
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req        = '0;
        req.raddr  = cnt_reg[IDX_BITS-1:0];
        req.laddr  = cnt_reg[IDX_BITS-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                    state_next = (cmd_t'(command) == CMD_CLEAR) ? ST_WRITE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg < CNT_BITS'(TABLE_DEPTH))
                    cnt_next = cnt_reg + CNT_BITS'(1);
                else if (!dv_reg)
                begin
                    // a linked forget goes round once more for its base
                    if (cmd_reg == CMD_FORGET && lm_reg && !pass_reg)
                        cnt_next = '0;
                    else
                        state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // forget reads its matched base entry, find its best entry
                state_next = ST_RESOLVE;
                req.raddr  = (cmd_reg == CMD_FORGET) ? rmi_reg : bi_reg;
            end
            ST_RESOLVE:
            begin
                req.raddr  = bi_reg;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
                if (cmd_reg == CMD_RECORD && in_reg.base != '0
                    && (rm_reg || rf_reg) && (lm_reg || lf_reg))
                begin
                    req.rwe    = 1'b1;
                    req.rwaddr = rm_reg ? rmi_reg : rfi_reg;
                    req.rwdata = in_reg;
                    req.lwe    = 1'b1;
                    req.lwaddr = lm_reg ? lmi_reg : lfi_reg;
                    req.lwdata = '{handle: in_reg.handle, base: in_reg.base};
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign hit            = hit_reg;
    assign forgot         = forgot_reg;
    assign table_full     = full_reg;
    assign found_base     = found_reg.base;
    assign found_length   = found_reg.length;
    assign found_flags    = found_reg.flags;
    assign found_device   = found_reg.device;
    assign found_handle   = found_reg.handle;
    assign found_offset   = found_reg.offset;
    assign recorded_count = total_reg;
endmodule
`default_nettype wire

// File: rtl/art_checker.sv
// Port-level checker for the address range table, bound to the top level.
// Depends on address_range_table ports only.
`default_nettype none
module art_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        hit,
    input wire logic        forgot,
    input wire logic        table_full,
    input wire logic [31:0] recorded_count
);
    // a result comes only after busy was high
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without command");
    // one flag at most per result
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({hit, forgot, table_full})) else $error("flags clash");
    // count moves only at a result
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(recorded_count) |-> done) else $error("count moved idle");
    // start while idle makes busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("command not taken");
endmodule

bind address_range_table art_checker u_art_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .hit(hit), .forgot(forgot), .table_full(table_full),
    .recorded_count(recorded_count)
);
`default_nettype wire
